// ===== sv/lar_pkg.sv =====
// shared constants, operation codes and request structs for the line rasterizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lar_pkg;
    localparam int FRAME_WIDTH  = 80;
    localparam int FRAME_HEIGHT = 24;
    localparam int FRAME_SIZE   = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W       = $clog2(FRAME_SIZE);

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
    } t_ram_req;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } t_div_req;
endpackage
`default_nettype wire

// ===== sv/lar_frame_ram.sv =====
// intensity frame store, one write and one registered read port
// depends on lar_pkg
`timescale 1ns / 1ps
`default_nettype none
module lar_frame_ram import lar_pkg::*; (
    input  wire logic     i_clk,
    input  wire t_ram_req i_req,
    output logic [7:0]    o_rdata
);
    logic [7:0] mem [FRAME_SIZE];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== sv/lar_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
// depends on lar_pkg
`timescale 1ns / 1ps
`default_nettype none
module lar_div import lar_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output logic          o_done,
    output logic [16:0]   o_quot
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [31:0] r_quo;
    logic [15:0] r_dvs;
    logic [16:0] trial;
    logic        qbit;
    logic [16:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[31]};
        qbit  = trial >= {1'b0, r_dvs};
        n_rem = qbit ? trial - {1'b0, r_dvs} : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem[15:0];
                r_quo <= {r_quo[30:0], qbit};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo[16:0];
endmodule
`default_nettype wire

// ===== sv/antialiased_line_raster.sv =====
// anti-aliased line rasterizer: read-modify-write sequencer over the frame store
// depends on lar_pkg, lar_frame_ram, lar_div
// read: S_READ then S_READW; clear: one write per frame address, then the result; op 3: result only
// draw: setup, the gradient divider, then per pixel pair the weight states and the writes,
//   one pair per endpoint and per inner column; each pair is two read-modify-write ops
// one item at a time: busy is high from acceptance until the result strobe
// after reset a clearing pass over every frame address runs with busy high and no result
`timescale 1ns / 1ps
`default_nettype none
module antialiased_line_raster import lar_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [1:0]         i_op,
    input  wire logic signed [14:0] i_start_x,
    input  wire logic signed [14:0] i_start_y,
    input  wire logic signed [14:0] i_end_x,
    input  wire logic signed [14:0] i_end_y,
    input  wire logic [6:0]         i_read_col,
    input  wire logic [4:0]         i_read_row,
    output logic                    o_valid,
    output logic [7:0]              o_pixel_value,
    output logic                    o_is_read
);
    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_SETUP, S_DIVGO, S_DIVW, S_PREP, S_PREP2,
        S_W0, S_W1, S_RD0, S_WR0, S_RD1, S_WR1, S_READ, S_READW, S_FINISH
    } t_state;

    typedef enum logic [1:0] {PH_END1, PH_END2, PH_INNER} t_phase;

    function automatic logic signed [9:0] round_px(input logic signed [14:0] v);
        logic signed [15:0] ve;
        logic [15:0]        m;
        logic [9:0]         q;
        ve = {v[14], v};
        m  = ve[15] ? 16'(-ve) : 16'(ve);
        m  = m + 16'd32;
        q  = m[15:6];
        return ve[15] ? -$signed(q) : $signed(q);
    endfunction

    t_state r_state;
    t_phase r_phase;
    logic   r_report;
    logic [ADDR_W-1:0] r_cnt;

    logic signed [14:0] r_sx, r_sy, r_ex, r_ey;
    logic [6:0]         r_rcol;
    logic [4:0]         r_rrow;

    logic signed [14:0] r_x0, r_y0, r_x1, r_y1;
    logic               r_steep;
    logic signed [17:0] r_g;
    logic signed [9:0]  r_xe1, r_xe2;
    logic signed [6:0]  r_t1, r_t2;
    logic [6:0]         r_gap1, r_gap2;
    logic signed [33:0] r_ya, r_yb, r_step;

    logic signed [9:0]  r_pa;
    logic signed [33:0] r_py;
    logic [6:0]         r_pgap;
    logic signed [11:0] r_yi;
    logic [29:0]        r_plo, r_phi;
    logic [7:0]         r_v0, r_v1;
    logic               r_ok0, r_ok1;
    logic [ADDR_W-1:0]  r_ad0, r_ad1;

    logic       r_valid;
    logic [7:0] r_pix;
    logic       r_isrd;

    t_ram_req   ram_req;
    t_div_req   div_req;
    logic [7:0] rdata;
    logic       div_done;
    logic [16:0] quot;

    lar_frame_ram u_ram (.i_clk(i_clk), .i_req(ram_req), .o_rdata(rdata));
    lar_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req),
        .o_done(div_done), .o_quot(quot)
    );

    // setup: steep test and endpoint ordering
    logic signed [15:0] dxs, dys;
    logic [15:0]        adx, ady;
    logic               steep;
    logic signed [14:0] a0, b0, a1, b1;
    always_comb begin
        dxs   = {r_ex[14], r_ex} - {r_sx[14], r_sx};
        dys   = {r_ey[14], r_ey} - {r_sy[14], r_sy};
        adx   = dxs[15] ? 16'(-dxs) : 16'(dxs);
        ady   = dys[15] ? 16'(-dys) : 16'(dys);
        steep = ady > adx;
        a0 = steep ? r_sy : r_sx;
        b0 = steep ? r_sx : r_sy;
        a1 = steep ? r_ey : r_ex;
        b1 = steep ? r_ex : r_ey;
    end

    // gradient division operands
    logic [15:0]        ldx;
    logic signed [15:0] ldy;
    logic [15:0]        abs_dy;
    always_comb begin
        ldx    = 16'({r_x1[14], r_x1} - {r_x0[14], r_x0});
        ldy    = {r_y1[14], r_y1} - {r_y0[14], r_y0};
        abs_dy = ldy[15] ? 16'(-ldy) : 16'(ldy);
        div_req.start    = (r_state == S_DIVGO);
        div_req.dividend = {abs_dy, 16'd0};
        div_req.divisor  = ldx;
    end

    // endpoint rounding
    logic signed [9:0]  xe1, xe2;
    logic signed [15:0] t1w, t2w;
    logic signed [6:0]  t1, t2;
    logic [6:0]         at1, at2;
    always_comb begin
        xe1 = round_px(r_x0);
        xe2 = round_px(r_x1);
        t1w = {r_x0[14], r_x0} - {xe1, 6'd0};
        t2w = {r_x1[14], r_x1} - {xe2, 6'd0};
        t1  = 7'(t1w);
        t2  = 7'(t2w);
        at1 = t1[6] ? 7'(-t1) : 7'(t1);
        at2 = t2[6] ? 7'(-t2) : 7'(t2);
    end

    logic signed [24:0] gt1, gt2;
    always_comb begin
        gt1 = r_g * r_t1;
        gt2 = r_g * r_t2;
    end

    // weights: r scaled by gap, then times 255 with rounding
    logic [22:0] rr;
    logic [37:0] s0, s1;
    logic signed [12:0] yi0, yi1, pa13;
    logic signed [12:0] c0, w0, c1, w1;
    logic ok0, ok1;
    always_comb begin
        rr   = 23'(1 << 22) - {1'b0, r_py[21:0]};
        s0   = {r_plo, 8'd0} - 38'(r_plo) + 38'(1 << 27);
        s1   = {r_phi, 8'd0} - 38'(r_phi) + 38'(1 << 27);
        yi0  = {r_yi[11], r_yi};
        yi1  = yi0 + 13'sd1;
        pa13 = {{3{r_pa[9]}}, r_pa};
        c0 = r_steep ? yi0 : pa13;
        w0 = r_steep ? pa13 : yi0;
        c1 = r_steep ? yi1 : pa13;
        w1 = r_steep ? pa13 : yi1;
        ok0 = (c0 >= 0) && (int'(c0) < FRAME_WIDTH) && (w0 >= 0) && (int'(w0) < FRAME_HEIGHT);
        ok1 = (c1 >= 0) && (int'(c1) < FRAME_WIDTH) && (w1 >= 0) && (int'(w1) < FRAME_HEIGHT);
    end

    logic              rd_ok;
    logic [ADDR_W-1:0] rd_addr;
    always_comb begin
        rd_ok   = (int'(r_rcol) < FRAME_WIDTH) && (int'(r_rrow) < FRAME_HEIGHT);
        rd_addr = ADDR_W'(r_rrow) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(r_rcol);
    end

    always_comb begin
        ram_req = '0;
        unique case (r_state)
            S_CLEAR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_cnt;
                ram_req.wdata = 8'd0;
            end
            S_RD0: begin
                ram_req.re    = r_ok0;
                ram_req.raddr = r_ad0;
            end
            S_WR0: begin
                ram_req.we    = r_ok0 && (r_v0 > rdata);
                ram_req.waddr = r_ad0;
                ram_req.wdata = r_v0;
            end
            S_RD1: begin
                ram_req.re    = r_ok1;
                ram_req.raddr = r_ad1;
            end
            S_WR1: begin
                ram_req.we    = r_ok1 && (r_v1 > rdata);
                ram_req.waddr = r_ad1;
                ram_req.wdata = r_v1;
            end
            S_READ: begin
                ram_req.re    = rd_ok;
                ram_req.raddr = rd_addr;
            end
            default: ram_req = '0;
        endcase
    end

    // next walk position
    logic signed [9:0]  nx;
    logic signed [33:0] ny;
    always_comb begin
        if (r_phase == PH_END2) begin
            nx = r_xe1 + 10'sd1;
            ny = r_ya + r_step;
        end else begin
            nx = r_pa + 10'sd1;
            ny = r_py + r_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_report <= 1'b0;
            r_phase  <= PH_END1;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_sx   <= i_start_x;
                        r_sy   <= i_start_y;
                        r_ex   <= i_end_x;
                        r_ey   <= i_end_y;
                        r_rcol <= i_read_col;
                        r_rrow <= i_read_row;
                        case (i_op)
                            OP_CLEAR: begin
                                r_cnt    <= '0;
                                r_report <= 1'b1;
                                r_state  <= S_CLEAR;
                            end
                            OP_DRAW: r_state <= S_SETUP;
                            OP_READ: r_state <= S_READ;
                            default: r_state <= S_FINISH;
                        endcase
                    end
                end
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (int'(r_cnt) == FRAME_SIZE - 1) begin
                        r_state <= r_report ? S_FINISH : S_IDLE;
                    end
                end
                S_SETUP: begin
                    r_steep <= steep;
                    if (a0 > a1) begin
                        r_x0 <= a1; r_y0 <= b1; r_x1 <= a0; r_y1 <= b0;
                    end else begin
                        r_x0 <= a0; r_y0 <= b0; r_x1 <= a1; r_y1 <= b1;
                    end
                    r_state <= S_DIVGO;
                end
                S_DIVGO: r_state <= S_DIVW;
                S_DIVW: begin
                    if (div_done) begin
                        if (ldx == 16'd0) begin
                            r_g <= 18'sd65536;
                        end else begin
                            r_g <= ldy[15] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
                        end
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_xe1  <= xe1;
                    r_xe2  <= xe2;
                    r_t1   <= t1;
                    r_t2   <= t2;
                    r_gap1 <= 7'd64 - at1;
                    r_gap2 <= at2;
                    r_state <= S_PREP2;
                end
                S_PREP2: begin
                    // y at each endpoint column, Q22
                    r_ya   <= {{3{r_y0[14]}}, r_y0, 16'd0} - 34'(gt1);
                    r_yb   <= {{3{r_y1[14]}}, r_y1, 16'd0} - 34'(gt2);
                    r_step <= {{10{r_g[17]}}, r_g, 6'd0};
                    r_pa   <= r_xe1;
                    r_py   <= {{3{r_y0[14]}}, r_y0, 16'd0} - 34'(gt1);
                    r_pgap <= r_gap1;
                    r_phase <= PH_END1;
                    r_state <= S_W0;
                end
                S_W0: begin
                    r_yi  <= r_py[33:22];
                    r_plo <= 30'(rr) * 30'(r_pgap);
                    r_phi <= 30'({1'b0, r_py[21:0]}) * 30'(r_pgap);
                    r_state <= S_W1;
                end
                S_W1: begin
                    r_v0  <= s0[35:28];
                    r_v1  <= s1[35:28];
                    r_ok0 <= ok0;
                    r_ok1 <= ok1;
                    r_ad0 <= ADDR_W'(w0) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(c0);
                    r_ad1 <= ADDR_W'(w1) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(c1);
                    r_state <= S_RD0;
                end
                S_RD0: r_state <= S_WR0;
                S_WR0: r_state <= S_RD1;
                S_RD1: r_state <= S_WR1;
                S_WR1: begin
                    if (r_phase == PH_END1) begin
                        r_pa    <= r_xe2;
                        r_py    <= r_yb;
                        r_pgap  <= r_gap2;
                        r_phase <= PH_END2;
                        r_state <= S_W0;
                    end else begin
                        r_pa    <= nx;
                        r_py    <= ny;
                        r_pgap  <= 7'd64;
                        r_phase <= PH_INNER;
                        r_state <= (nx < r_xe2) ? S_W0 : S_FINISH;
                    end
                end
                S_READ: r_state <= S_READW;
                S_READW: begin
                    r_valid <= 1'b1;
                    r_pix   <= rd_ok ? rdata : 8'd0;
                    r_isrd  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_FINISH: begin
                    r_valid <= 1'b1;
                    r_pix   <= 8'd0;
                    r_isrd  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_pixel_value = r_pix;
    assign o_is_read     = r_isrd;
endmodule
`default_nettype wire

// ===== sv/lar_checker.sv =====
// port-level assertions for the line rasterizer, bound to the top level
// depends on antialiased_line_raster
`timescale 1ns / 1ps
`default_nettype none
module lar_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_start,
    input wire logic       o_busy,
    input wire logic       o_valid,
    input wire logic [7:0] o_pixel_value,
    input wire logic       o_is_read
);
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy) else $error("result while busy");
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("back to back results");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("request not taken");
    a_zero_nonread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_read) |-> (o_pixel_value == 8'd0))
        else $error("nonzero value on non-read result");
endmodule

bind antialiased_line_raster lar_checker u_lar_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_valid(o_valid), .o_pixel_value(o_pixel_value), .o_is_read(o_is_read)
);
`default_nettype wire
